// ===== rtl/cmvm_pkg.sv =====
`timescale 1ns / 1ps

package cmvm_pkg;

    // Widths of the loaded parts, the products and the exact row sums.
    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int SUM_W  = 37;
    localparam int CNT_W  = 5;
    localparam int IDX_W  = 4;
    localparam int CFG_IDX_W = 2;

    // Action codes of an input word.
    localparam logic [1:0] ACT_LOAD_MATRIX = 2'd0;
    localparam logic [1:0] ACT_LOAD_VECTOR = 2'd1;
    localparam logic [1:0] ACT_COMPUTE     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;

    // One complex Q1.14 element.
    typedef struct packed {
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
    } cplx_t;

    // Control of the shared complex multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

endpackage

// ===== rtl/cmvm_mac.sv =====
`timescale 1ns / 1ps

module cmvm_mac (
    input  logic                                aclk,
    input  cmvm_pkg::mac_ctrl_t                 ctrl,
    input  cmvm_pkg::cplx_t                     a,
    input  cmvm_pkg::cplx_t                     b,
    output logic signed [cmvm_pkg::SUM_W-1:0]   acc_re,
    output logic signed [cmvm_pkg::SUM_W-1:0]   acc_im
);

    logic signed [cmvm_pkg::PROD_W-1:0] p_rr_reg;
    logic signed [cmvm_pkg::PROD_W-1:0] p_ii_reg;
    logic signed [cmvm_pkg::PROD_W-1:0] p_ri_reg;
    logic signed [cmvm_pkg::PROD_W-1:0] p_ir_reg;
    logic signed [cmvm_pkg::SUM_W-1:0]  acc_re_reg;
    logic signed [cmvm_pkg::SUM_W-1:0]  acc_im_reg;

    // The four partial products of one complex multiply are registered.
    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            p_rr_reg <= cmvm_pkg::PROD_W'(a.re) * cmvm_pkg::PROD_W'(b.re);
            p_ii_reg <= cmvm_pkg::PROD_W'(a.im) * cmvm_pkg::PROD_W'(b.im);
            p_ri_reg <= cmvm_pkg::PROD_W'(a.re) * cmvm_pkg::PROD_W'(b.im);
            p_ir_reg <= cmvm_pkg::PROD_W'(a.im) * cmvm_pkg::PROD_W'(b.re);
        end
    end

    // The accumulators keep the exact sum, so they never overflow.
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (ctrl.acc_en) begin
            acc_re_reg <= acc_re_reg + cmvm_pkg::SUM_W'(p_rr_reg)
                          - cmvm_pkg::SUM_W'(p_ii_reg);
            acc_im_reg <= acc_im_reg + cmvm_pkg::SUM_W'(p_ri_reg)
                          + cmvm_pkg::SUM_W'(p_ir_reg);
        end
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule

// ===== rtl/complex_matrix_vector_multiply.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake             | Words
// s_       | in        | s_valid / s_ready     | matrix load, vector load, compute
// m_       | out       | m_valid / m_ready     | one row sum per row in use
// cfg_     | in        | cfg_valid / cfg_ready | rows_in_use, cols_in_use
//
// A compute is done by the single shared complex multiply-accumulate unit, which
// takes each column through a memory read, a multiply and an accumulate step.
// No input word is taken while a compute runs; a stalled result holds the
// sequencer at the end of that row. Reset (aresetn, synchronous) clears control
// state only; the matrix and vector memories hold nothing until written.

module complex_matrix_vector_multiply #(
    parameter int DIM = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_action,
    input  logic [cmvm_pkg::IDX_W-1:0]            s_row_index,
    input  logic [cmvm_pkg::IDX_W-1:0]            s_col_index,
    input  logic signed [cmvm_pkg::VAL_W-1:0]     s_value_re,
    input  logic signed [cmvm_pkg::VAL_W-1:0]     s_value_im,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [cmvm_pkg::IDX_W-1:0]            m_out_row,
    output logic signed [cmvm_pkg::SUM_W-1:0]     m_out_re,
    output logic signed [cmvm_pkg::SUM_W-1:0]     m_out_im,
    output logic                                  m_last,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cmvm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cmvm_pkg::CNT_W-1:0]            cfg_data
);

    localparam int MAT_AW = $clog2(DIM * DIM);
    localparam int VEC_AW = $clog2(DIM);
    localparam logic [cmvm_pkg::CNT_W-1:0] ROW_LIMIT =
        cmvm_pkg::CNT_W'((DIM < 16) ? DIM : 16);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ACC,
        S_EMIT
    } state_t;

    state_t                          state_reg;
    logic [cmvm_pkg::CNT_W-1:0]      rows_cfg_reg;
    logic [cmvm_pkg::CNT_W-1:0]      cols_cfg_reg;
    logic [cmvm_pkg::CNT_W-1:0]      nr_reg;
    logic [cmvm_pkg::CNT_W-1:0]      nc_reg;
    logic [cmvm_pkg::IDX_W-1:0]      row_reg;
    logic [cmvm_pkg::IDX_W-1:0]      col_reg;
    logic                            m_valid_reg;
    logic [cmvm_pkg::IDX_W-1:0]      m_row_reg;
    logic signed [cmvm_pkg::SUM_W-1:0] m_re_reg;
    logic signed [cmvm_pkg::SUM_W-1:0] m_im_reg;
    logic                            m_last_reg;

    cmvm_pkg::cplx_t                 mat_mem [DIM*DIM];
    cmvm_pkg::cplx_t                 vec_mem [DIM];
    cmvm_pkg::cplx_t                 mat_q_reg;
    cmvm_pkg::cplx_t                 vec_q_reg;
    cmvm_pkg::cplx_t                 load_val;
    cmvm_pkg::mac_ctrl_t             mac_ctrl;

    logic                            in_fire;
    logic                            out_free;
    logic                            row_done;
    logic                            col_done;
    logic [MAT_AW-1:0]               load_mat_addr;
    logic [MAT_AW-1:0]               read_mat_addr;
    logic signed [cmvm_pkg::SUM_W-1:0] acc_re;
    logic signed [cmvm_pkg::SUM_W-1:0] acc_im;

    // Clamp a count register into the range one to the row limit.
    function automatic logic [cmvm_pkg::CNT_W-1:0] clamp_count(
        input logic [cmvm_pkg::CNT_W-1:0] v
    );
        logic [cmvm_pkg::CNT_W-1:0] r;
        if (v == '0) begin
            r = cmvm_pkg::CNT_W'(1);
        end else if (v > ROW_LIMIT) begin
            r = ROW_LIMIT;
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign col_done  = (cmvm_pkg::CNT_W'(col_reg) + cmvm_pkg::CNT_W'(1)) == nc_reg;
    assign row_done  = (cmvm_pkg::CNT_W'(row_reg) + cmvm_pkg::CNT_W'(1)) == nr_reg;

    assign load_val.re   = s_value_re;
    assign load_val.im   = s_value_im;
    assign load_mat_addr = MAT_AW'(32'(s_row_index) * DIM + 32'(s_col_index));
    assign read_mat_addr = MAT_AW'(32'(row_reg) * DIM + 32'(col_reg));

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= cmvm_pkg::CNT_W'(16);
            cols_cfg_reg <= cmvm_pkg::CNT_W'(16);
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == cmvm_pkg::CFG_ROWS_IN_USE) begin
                rows_cfg_reg <= cfg_data;
            end else if (cfg_index == cmvm_pkg::CFG_COLS_IN_USE) begin
                cols_cfg_reg <= cfg_data;
            end
        end
    end

    // Matrix and vector memories: written by load words, read by the sequencer.
    always_ff @(posedge aclk) begin
        if (in_fire && s_action == cmvm_pkg::ACT_LOAD_MATRIX
            && 32'(s_row_index) < DIM && 32'(s_col_index) < DIM) begin
            mat_mem[load_mat_addr] <= load_val;
        end
        if (state_reg == S_READ) begin
            mat_q_reg <= mat_mem[read_mat_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && s_action == cmvm_pkg::ACT_LOAD_VECTOR
            && 32'(s_col_index) < DIM) begin
            vec_mem[VEC_AW'(s_col_index)] <= load_val;
        end
        if (state_reg == S_READ) begin
            vec_q_reg <= vec_mem[VEC_AW'(col_reg)];
        end
    end

    // Controls of the shared multiply-accumulate unit follow the state.
    always_comb begin
        mac_ctrl.clear  = (state_reg == S_IDLE) || (state_reg == S_EMIT && out_free);
        mac_ctrl.mul_en = (state_reg == S_MUL);
        mac_ctrl.acc_en = (state_reg == S_ACC);
    end

    cmvm_mac u_mac (
        .aclk   (aclk),
        .ctrl   (mac_ctrl),
        .a      (mat_q_reg),
        .b      (vec_q_reg),
        .acc_re (acc_re),
        .acc_im (acc_im)
    );

    // Sequencer: walks the columns of each row, then hands the row sum out.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            row_reg     <= '0;
            col_reg     <= '0;
            nr_reg      <= cmvm_pkg::CNT_W'(1);
            nc_reg      <= cmvm_pkg::CNT_W'(1);
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_fire && s_action == cmvm_pkg::ACT_COMPUTE) begin
                        nr_reg    <= clamp_count(rows_cfg_reg);
                        nc_reg    <= clamp_count(cols_cfg_reg);
                        row_reg   <= '0;
                        col_reg   <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    if (col_done) begin
                        state_reg <= S_EMIT;
                    end else begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_row_reg   <= row_reg;
                        m_re_reg    <= acc_re;
                        m_im_reg    <= acc_im;
                        m_last_reg  <= row_done;
                        col_reg     <= '0;
                        if (row_done) begin
                            state_reg <= S_IDLE;
                        end else begin
                            row_reg   <= row_reg + 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_out_row = m_row_reg;
    assign m_out_re  = m_re_reg;
    assign m_out_im  = m_im_reg;
    assign m_last    = m_last_reg;

endmodule

// ===== test/tb_complex_matrix_vector_multiply.sv =====
`timescale 1ns / 1ps

module tb_complex_matrix_vector_multiply;

    localparam int          MAT_DIM     = 16;
    localparam int          HANG_LIMIT  = 4000;
    localparam int          LONG_HOLD   = 400;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam logic [1:0]  CFG_SPARE_A = 2'd2;
    localparam logic [1:0]  CFG_SPARE_B = 2'd3;

    // One input word as the sender offers it.
    typedef struct {
        logic [1:0]                        action;
        logic [cmvm_pkg::IDX_W-1:0]        row;
        logic [cmvm_pkg::IDX_W-1:0]        col;
        logic signed [cmvm_pkg::VAL_W-1:0] re;
        logic signed [cmvm_pkg::VAL_W-1:0] im;
    } gate_word_t;

    // One row sum as the block should return it.
    typedef struct {
        logic [cmvm_pkg::IDX_W-1:0]        row;
        logic signed [cmvm_pkg::SUM_W-1:0] re;
        logic signed [cmvm_pkg::SUM_W-1:0] im;
        logic                              last;
    } row_sum_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                              s_valid     = 1'b0;
    logic                              s_ready;
    logic [1:0]                        s_action    = '0;
    logic [cmvm_pkg::IDX_W-1:0]        s_row_index = '0;
    logic [cmvm_pkg::IDX_W-1:0]        s_col_index = '0;
    logic signed [cmvm_pkg::VAL_W-1:0] s_value_re  = '0;
    logic signed [cmvm_pkg::VAL_W-1:0] s_value_im  = '0;

    logic                              m_valid;
    logic                              m_ready     = 1'b0;
    logic [cmvm_pkg::IDX_W-1:0]        m_out_row;
    logic signed [cmvm_pkg::SUM_W-1:0] m_out_re;
    logic signed [cmvm_pkg::SUM_W-1:0] m_out_im;
    logic                              m_last;

    logic                              cfg_valid   = 1'b0;
    logic                              cfg_ready;
    logic [cmvm_pkg::CFG_IDX_W-1:0]    cfg_index   = '0;
    logic [cmvm_pkg::CNT_W-1:0]        cfg_data    = '0;

    // Words waiting to be offered and row sums waiting to arrive.
    gate_word_t pending_words[$];
    row_sum_t   row_sums_due[$];

    // Predicted contents of the block: matrix, vector and the two counts.
    logic signed [cmvm_pkg::VAL_W-1:0] mat_re [MAT_DIM][MAT_DIM];
    logic signed [cmvm_pkg::VAL_W-1:0] mat_im [MAT_DIM][MAT_DIM];
    logic signed [cmvm_pkg::VAL_W-1:0] vec_re [MAT_DIM];
    logic signed [cmvm_pkg::VAL_W-1:0] vec_im [MAT_DIM];
    logic [cmvm_pkg::CNT_W-1:0]        rows_reg = cmvm_pkg::CNT_W'(16);
    logic [cmvm_pkg::CNT_W-1:0]        cols_reg = cmvm_pkg::CNT_W'(16);

    // Entries already loaded by the generated stream, so computes never read garbage.
    bit mat_loaded [MAT_DIM][MAT_DIM];
    bit vec_loaded [MAT_DIM];

    // Shared knobs set by the stimulus sequence.
    bit calm             = 1'b0;
    bit long_hold_armed  = 1'b0;

    int errors         = 0;
    int words_queued   = 0;
    int words_accepted = 0;
    int computes_seen  = 0;
    int sums_checked   = 0;
    int reg_writes     = 0;

    complex_matrix_vector_multiply #(.DIM(MAT_DIM)) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_row_index (s_row_index),
        .s_col_index (s_col_index),
        .s_value_re  (s_value_re),
        .s_value_im  (s_value_im),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_row   (m_out_row),
        .m_out_re    (m_out_re),
        .m_out_im    (m_out_im),
        .m_last      (m_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // A count register of zero acts as one, and anything past the array size as the size.
    function automatic int eff_count(input logic [cmvm_pkg::CNT_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAT_DIM) return MAT_DIM;
        return int'(v);
    endfunction

    // Idle lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Operand values with the range corners mixed in.
    function automatic logic signed [cmvm_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return cmvm_pkg::VAL_W'($urandom);
        endcase
    endfunction

    // Work out every row sum of a compute from the predicted matrix and vector.
    task automatic predict_row_sums();
        longint   acc_re, acc_im;
        longint   ar, ai, br, bi;
        row_sum_t s;
        int       nr, nc;
        nr = eff_count(rows_reg);
        nc = eff_count(cols_reg);
        for (int i = 0; i < nr; i++) begin
            acc_re = 0;
            acc_im = 0;
            for (int j = 0; j < nc; j++) begin
                ar = mat_re[i][j];
                ai = mat_im[i][j];
                br = vec_re[j];
                bi = vec_im[j];
                acc_re += ar * br - ai * bi;
                acc_im += ar * bi + ai * br;
            end
            s.row  = cmvm_pkg::IDX_W'(i);
            s.re   = acc_re[cmvm_pkg::SUM_W-1:0];
            s.im   = acc_im[cmvm_pkg::SUM_W-1:0];
            s.last = (i == nr - 1);
            row_sums_due.push_back(s);
        end
    endtask

    // Update the prediction with one accepted word.
    task automatic apply_word(input gate_word_t w);
        case (w.action)
            cmvm_pkg::ACT_LOAD_MATRIX: begin
                mat_re[w.row][w.col] = w.re;
                mat_im[w.row][w.col] = w.im;
            end
            cmvm_pkg::ACT_LOAD_VECTOR: begin
                vec_re[w.col] = w.re;
                vec_im[w.col] = w.im;
            end
            cmvm_pkg::ACT_COMPUTE: begin
                computes_seen++;
                predict_row_sums();
            end
            default: ;
        endcase
    endtask

    // Input driver: offers queued words with random gaps between them.
    gate_word_t cur_word;
    int         send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                words_accepted++;
                apply_word(cur_word);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0 || pending_words.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    s_valid <= 1'b0;
                end else begin
                    cur_word = pending_words.pop_front();
                    s_valid     <= 1'b1;
                    s_action    <= cur_word.action;
                    s_row_index <= cur_word.row;
                    s_col_index <= cur_word.col;
                    s_value_re  <= cur_word.re;
                    s_value_im  <= cur_word.im;
                    send_gap = pick_gap();
                end
            end
        end
    end

    // Result monitor: checks each row sum and drives m_ready with random stalls.
    row_sum_t want;
    int       stall_left = 0;
    int       hold_left  = 0;
    bit       hold_done  = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (row_sums_due.size() == 0) begin
                    $display("%0t: row sum with none expected: row %0d re %0d im %0d last %0b",
                             $time, m_out_row, m_out_re, m_out_im, m_last);
                    errors++;
                end else begin
                    want = row_sums_due.pop_front();
                    sums_checked++;
                    if (m_out_row !== want.row) begin
                        $display("%0t: out_row expected %0d actual %0d",
                                 $time, want.row, m_out_row);
                        errors++;
                    end
                    if (m_out_re !== want.re) begin
                        $display("%0t: out_re of row %0d expected %0d actual %0d",
                                 $time, want.row, want.re, m_out_re);
                        errors++;
                    end
                    if (m_out_im !== want.im) begin
                        $display("%0t: out_im of row %0d expected %0d actual %0d",
                                 $time, want.row, want.im, m_out_im);
                        errors++;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t: last of row %0d expected %0b actual %0b",
                                 $time, want.row, want.last, m_last);
                        errors++;
                    end
                end
            end
            // One long hold-off on the first result after it is armed, so the input backs up.
            if (long_hold_armed && !hold_done && m_valid) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Watchdog: ends the run when no word moves on any channel for too long.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d row sums outstanding",
                         $time, HANG_LIMIT, row_sums_due.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Write one configuration register and mirror it in the prediction.
    task automatic write_reg(input logic [cmvm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cmvm_pkg::CNT_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == cmvm_pkg::CFG_ROWS_IN_USE) rows_reg = val;
        else if (idx == cmvm_pkg::CFG_COLS_IN_USE) cols_reg = val;
    endtask

    // Wait until every queued word is accepted and every row sum is out, then settle.
    task automatic drain();
        while (words_accepted != words_queued || row_sums_due.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic push_word(input logic [1:0] act, input int row, input int col,
                             input logic signed [cmvm_pkg::VAL_W-1:0] re,
                             input logic signed [cmvm_pkg::VAL_W-1:0] im);
        gate_word_t w;
        w.action = act;
        w.row    = cmvm_pkg::IDX_W'(row);
        w.col    = cmvm_pkg::IDX_W'(col);
        w.re     = re;
        w.im     = im;
        if (act == cmvm_pkg::ACT_LOAD_MATRIX) mat_loaded[row][col] = 1'b1;
        if (act == cmvm_pkg::ACT_LOAD_VECTOR) vec_loaded[col] = 1'b1;
        words_queued++;
        pending_words.push_back(w);
    endtask

    // Queue a compute, first loading any entry in use that was never written.
    task automatic push_compute();
        int nr, nc;
        nr = eff_count(rows_reg);
        nc = eff_count(cols_reg);
        for (int j = 0; j < nc; j++) begin
            if (!vec_loaded[j])
                push_word(cmvm_pkg::ACT_LOAD_VECTOR, $urandom_range(0, 15), j,
                          pick_value(), pick_value());
            for (int i = 0; i < nr; i++)
                if (!mat_loaded[i][j])
                    push_word(cmvm_pkg::ACT_LOAD_MATRIX, i, j, pick_value(), pick_value());
        end
        push_word(cmvm_pkg::ACT_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                  cmvm_pkg::VAL_W'($urandom), cmvm_pkg::VAL_W'($urandom));
    endtask

    // Random loads and computes, mostly aimed at the entries in use, with some noise.
    task automatic random_phase(input int n);
        int start, r, nr, nc, row, col;
        start = pending_words.size() + words_accepted;
        nr = eff_count(rows_reg);
        nc = eff_count(cols_reg);
        while (pending_words.size() + words_accepted - start < n) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 4) != 0) begin
                row = $urandom_range(0, nr - 1);
                col = $urandom_range(0, nc - 1);
            end else begin
                row = $urandom_range(0, 15);
                col = $urandom_range(0, 15);
            end
            if (r < 10)
                push_compute();
            else if (r < 14)
                push_word(ACT_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                          cmvm_pkg::VAL_W'($urandom), cmvm_pkg::VAL_W'($urandom));
            else if (r < 60)
                push_word(cmvm_pkg::ACT_LOAD_MATRIX, row, col, pick_value(), pick_value());
            else
                push_word(cmvm_pkg::ACT_LOAD_VECTOR, $urandom_range(0, 15), col,
                          pick_value(), pick_value());
        end
        push_compute();
        drain();
    endtask

    // Stimulus sequence: reset, directed corners, then random phases over several settings.
    initial begin
        for (int i = 0; i < MAT_DIM; i++) begin
            vec_re[i] = '0;
            vec_im[i] = '0;
            for (int j = 0; j < MAT_DIM; j++) begin
                mat_re[i][j] = '0;
                mat_im[i][j] = '0;
            end
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed part on a 2 x 2 window: operand extremes, ignored code, idle entries.
        write_reg(cmvm_pkg::CFG_ROWS_IN_USE, 5'd2);
        write_reg(cmvm_pkg::CFG_COLS_IN_USE, 5'd2);
        push_word(cmvm_pkg::ACT_LOAD_MATRIX, 0, 0, -16'sd32768, -16'sd32768);
        push_word(cmvm_pkg::ACT_LOAD_MATRIX, 0, 1, 16'sd32767, 16'sd32767);
        push_word(cmvm_pkg::ACT_LOAD_MATRIX, 1, 0, -16'sd32768, 16'sd32767);
        push_word(cmvm_pkg::ACT_LOAD_MATRIX, 1, 1, 16'sd32767, -16'sd32768);
        push_word(cmvm_pkg::ACT_LOAD_VECTOR, 15, 0, -16'sd32768, -16'sd32768);
        push_word(cmvm_pkg::ACT_LOAD_VECTOR, 0, 1, 16'sd32767, -16'sd32768);
        push_word(ACT_UNUSED, 15, 15, 16'sh7fff, -16'sd1);
        push_compute();
        push_word(cmvm_pkg::ACT_LOAD_MATRIX, 15, 15, 16'sd0, -16'sd1);
        push_word(cmvm_pkg::ACT_LOAD_VECTOR, 0, 15, -16'sd1, 16'sd0);
        push_word(cmvm_pkg::ACT_LOAD_VECTOR, 0, 0, 16'sd0, 16'sd0);
        push_compute();
        push_word(ACT_UNUSED, 15, 15, -16'sd1, -16'sd1);
        push_word(cmvm_pkg::ACT_LOAD_MATRIX, 0, 0, 16'sd1, -16'sd1);
        push_compute();
        drain();

        // Smallest window.
        write_reg(cmvm_pkg::CFG_ROWS_IN_USE, 5'd1);
        write_reg(cmvm_pkg::CFG_COLS_IN_USE, 5'd1);
        random_phase(20);

        // Zero rows acts as one, oversized columns as the full width; no idling here.
        write_reg(cmvm_pkg::CFG_ROWS_IN_USE, 5'd0);
        write_reg(cmvm_pkg::CFG_COLS_IN_USE, 5'd31);
        calm = 1'b1;
        random_phase(30);
        calm = 1'b0;

        // Spare indexes are ignored; then the full array with one long output stall.
        write_reg(CFG_SPARE_A, 5'd5);
        write_reg(CFG_SPARE_B, 5'd31);
        write_reg(cmvm_pkg::CFG_ROWS_IN_USE, 5'd16);
        write_reg(cmvm_pkg::CFG_COLS_IN_USE, 5'd16);
        long_hold_armed = 1'b1;
        random_phase(300);

        // Oversized rows, zero columns.
        write_reg(cmvm_pkg::CFG_ROWS_IN_USE, 5'd17);
        write_reg(cmvm_pkg::CFG_COLS_IN_USE, 5'd0);
        random_phase(30);

        // A couple of arbitrary settings.
        repeat (2) begin
            write_reg(cmvm_pkg::CFG_ROWS_IN_USE, cmvm_pkg::CNT_W'($urandom_range(0, 31)));
            write_reg(cmvm_pkg::CFG_COLS_IN_USE, cmvm_pkg::CNT_W'($urandom_range(0, 31)));
            random_phase(30);
        end

        repeat (50) @(posedge aclk);
        $display("Sent %0d words including %0d computes, checked %0d row sums,",
                 words_accepted, computes_seen, sums_checked);
        $display("over %0d register writes, with %0d mismatches.", reg_writes, errors);
        if (errors == 0 && row_sums_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
